/* rtl/core/rmq_pkg.sv */
// Shared types and constants for the rotation matrix to quaternion unit.
// Used by rmq_sqrt, rmq_div and the top level; depends on nothing.
`default_nettype none
package rmq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = 18;
  localparam int SUM_W     = FIELD_W + 2;          // one plus three entries
  localparam int DIFF_W    = FIELD_W + 1;          // sum or difference of two entries
  localparam int MAG_W     = DIFF_W;               // magnitude of a difference
  localparam int RAD_W     = 2 * ((SUM_W - 1 + FRAC_BITS - 2 + 1) / 2);
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 3;
  localparam int NUM_W     = MAG_W + FRAC_BITS;
  localparam int DEN_W     = ROOT_W + 2;
  localparam int QUO_W     = FIELD_W;
  localparam int PREM_W    = DEN_W;
  localparam int LANES     = 3;
  localparam int IN_W      = 168;
  localparam int OUT_W     = 4 * FIELD_W;

  localparam logic [FIELD_W-1:0] LIM =
      ((1 << FRAC_BITS) > ((1 << (FIELD_W - 1)) - 1)) ?
      FIELD_W'((1 << (FIELD_W - 1)) - 1) : FIELD_W'(1 << FRAC_BITS);
  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1 << FRAC_BITS);
  localparam logic [ROOT_W-1:0] C_MIN = ROOT_W'(1 << (FRAC_BITS - 1));

  typedef enum logic [1:0] {
    SEL_W = 2'd0,
    SEL_X = 2'd1,
    SEL_Y = 2'd2,
    SEL_Z = 2'd3
  } sel_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } lane_t;

  typedef struct packed {
    sel_t              sel;
    lane_t [LANES-1:0] lanes;
  } sqrt_side_t;

  typedef struct packed {
    sel_t              sel;
    logic [ROOT_W-1:0] c;
    logic [LANES-1:0]  neg;
  } div_side_t;

endpackage
`default_nettype wire

/* rtl/core/rotation_matrix_to_quaternion_unit.sv */
// Top level: rotation matrix to unit quaternion (largest trace sum selects the pivot).
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
//
//  channel  dir  handshake           payload
//  in_      in   in_tvalid/tready    m00..m22, 18 bits each
//  out_     out  out_tvalid/tready   qx, qy, qz, qw, 18 bits each
//
// One word per cycle in and out unless the output stalls. Stages: trace sums, pivot
// select, 17 square root stages, 1 rounding stage, 18 divider stages, 1 output.
// rst_n is synchronous and clears only the valid bits.
// A held output word stalls every stage at once; nothing is dropped or repeated.
`default_nettype none
module rotation_matrix_to_quaternion_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // m00,m01,m02,m10,m11,m12,m20,m21,m22 (18 bits each), then 6 zero bits
  input  wire logic [rmq_pkg::IN_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // qx, qy, qz, qw (18 bits each)
  output logic [rmq_pkg::OUT_W-1:0]       out_tdata
);

  localparam int FW = rmq_pkg::FIELD_W;
  localparam int SW = rmq_pkg::SUM_W;
  localparam int DW = rmq_pkg::DIFF_W;
  localparam int L  = rmq_pkg::LANES;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---- stage 1: trace sums and off-diagonal terms
  logic signed [SW-1:0] m [0:8];
  for (genvar i = 0; i < 9; i++) begin : g_unpack
    assign m[i] = {{(SW-FW){in_tdata[FW*i+FW-1]}}, in_tdata[FW*i +: FW]};
  end

  logic                 v1_r;
  logic signed [SW-1:0] sw_r, sx_r, sy_r, sz_r;
  logic signed [DW-1:0] da_r, db_r, dc_r, sa_r, sb_r, sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sw_r <= rmq_pkg::ONE + m[0] + m[4] + m[8];
      sx_r <= rmq_pkg::ONE + m[0] - m[4] - m[8];
      sy_r <= rmq_pkg::ONE - m[0] + m[4] - m[8];
      sz_r <= rmq_pkg::ONE - m[0] - m[4] + m[8];
      da_r <= DW'(m[7] - m[5]);
      db_r <= DW'(m[2] - m[6]);
      dc_r <= DW'(m[3] - m[1]);
      sa_r <= DW'(m[3] + m[1]);
      sb_r <= DW'(m[6] + m[2]);
      sc_r <= DW'(m[7] + m[5]);
    end
  end

  // ---- stage 2: pivot select, ties to w then x, y, z
  logic                 ge_wx, ge_yz, ge_ab;
  logic signed [SW-1:0] max_a, max_b, max_s;
  rmq_pkg::sel_t        sel_a, sel_b, sel_s;
  logic signed [DW-1:0] lane_d [0:L-1];
  rmq_pkg::sqrt_side_t  side2_nxt;

  always_comb begin
    ge_wx = (sw_r >= sx_r);
    max_a = ge_wx ? sw_r : sx_r;
    sel_a = ge_wx ? rmq_pkg::SEL_W : rmq_pkg::SEL_X;
    ge_yz = (sy_r >= sz_r);
    max_b = ge_yz ? sy_r : sz_r;
    sel_b = ge_yz ? rmq_pkg::SEL_Y : rmq_pkg::SEL_Z;
    ge_ab = (max_a >= max_b);
    max_s = ge_ab ? max_a : max_b;
    sel_s = ge_ab ? sel_a : sel_b;
    // lanes fill the non-pivot slots in x, y, z, w order
    case (sel_s)
      rmq_pkg::SEL_W: begin lane_d[0] = da_r; lane_d[1] = db_r; lane_d[2] = dc_r; end
      rmq_pkg::SEL_X: begin lane_d[0] = sa_r; lane_d[1] = sb_r; lane_d[2] = da_r; end
      rmq_pkg::SEL_Y: begin lane_d[0] = sa_r; lane_d[1] = sc_r; lane_d[2] = db_r; end
      default:        begin lane_d[0] = sb_r; lane_d[1] = sc_r; lane_d[2] = dc_r; end
    endcase
    side2_nxt.sel = sel_s;
    for (int j = 0; j < L; j++) begin
      side2_nxt.lanes[j].neg = lane_d[j][DW-1];
      side2_nxt.lanes[j].mag = lane_d[j][DW-1] ? (~lane_d[j] + 1'b1) : lane_d[j];
    end
  end

  logic                       v2_r;
  logic [rmq_pkg::RAD_W-1:0]  rad2_r;
  rmq_pkg::sqrt_side_t        side2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  // the maximum is at least one, so its sign bit is clear
  always_ff @(posedge clk) begin
    if (en) begin
      rad2_r  <= rmq_pkg::RAD_W'({max_s[SW-2:0], {(rmq_pkg::FRAC_BITS-2){1'b0}}});
      side2_r <= side2_nxt;
    end
  end

  // ---- square root
  logic                        sq_valid;
  logic [rmq_pkg::ROOT_W-1:0]  sq_root;
  logic [rmq_pkg::REM_W-1:0]   sq_rem;
  rmq_pkg::sqrt_side_t         sq_side;

  rmq_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .in_rad    (rad2_r),
    .in_side   (side2_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_rem   (sq_rem),
    .out_side  (sq_side)
  );

  // ---- round root, build divisor 4c and dividends |D|*2^F + 2c
  logic [rmq_pkg::ROOT_W-1:0]           c_rnd;
  logic                                 v3_r;
  logic [rmq_pkg::DEN_W-1:0]            den3_r;
  logic [L-1:0][rmq_pkg::NUM_W-1:0]     num3_r;
  rmq_pkg::div_side_t                   side3_r;

  assign c_rnd = sq_root + rmq_pkg::ROOT_W'(sq_rem > rmq_pkg::REM_W'(sq_root));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den3_r      <= {c_rnd, 2'b00};
      side3_r.sel <= sq_side.sel;
      side3_r.c   <= c_rnd;
      for (int j = 0; j < L; j++) begin
        side3_r.neg[j] <= sq_side.lanes[j].neg;
        num3_r[j] <= {sq_side.lanes[j].mag, {rmq_pkg::FRAC_BITS{1'b0}}}
                     + rmq_pkg::NUM_W'({c_rnd, 1'b0});
      end
    end
  end

  // ---- divide
  logic                                dv_valid;
  logic [L-1:0][rmq_pkg::QUO_W-1:0]    dv_quo;
  rmq_pkg::div_side_t                  dv_side;

  rmq_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_den    (den3_r),
    .in_num    (num3_r),
    .in_side   (side3_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // ---- saturate, restore sign, place pivot
  logic [FW-1:0] lane_q [0:L-1];
  logic [FW-1:0] c_sat;
  logic [FW-1:0] qx_nxt, qy_nxt, qz_nxt, qw_nxt;

  always_comb begin
    for (int j = 0; j < L; j++) begin
      lane_q[j] = (dv_quo[j] > rmq_pkg::LIM) ? rmq_pkg::LIM : dv_quo[j];
      if (dv_side.neg[j]) begin
        lane_q[j] = ~lane_q[j] + 1'b1;
      end
    end
    c_sat = (FW'(dv_side.c) > rmq_pkg::LIM) ? rmq_pkg::LIM : FW'(dv_side.c);
    case (dv_side.sel)
      rmq_pkg::SEL_W: begin
        qx_nxt = lane_q[0]; qy_nxt = lane_q[1]; qz_nxt = lane_q[2]; qw_nxt = c_sat;
      end
      rmq_pkg::SEL_X: begin
        qx_nxt = c_sat; qy_nxt = lane_q[0]; qz_nxt = lane_q[1]; qw_nxt = lane_q[2];
      end
      rmq_pkg::SEL_Y: begin
        qx_nxt = lane_q[0]; qy_nxt = c_sat; qz_nxt = lane_q[1]; qw_nxt = lane_q[2];
      end
      default: begin
        qx_nxt = lane_q[0]; qy_nxt = lane_q[1]; qz_nxt = c_sat; qw_nxt = lane_q[2];
      end
    endcase
  end

  logic                       out_valid_r;
  logic [rmq_pkg::OUT_W-1:0]  out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {qw_nxt, qz_nxt, qy_nxt, qx_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---- checks
  logic signed [FW-1:0] chk_qw;
  assign chk_qw = out_data_r[4*FW-1 -: FW];

  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (side3_r.c >= rmq_pkg::C_MIN))
    else $error("rounded root below half of one");

  a_qw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((chk_qw <= $signed(rmq_pkg::LIM)) && (chk_qw >= -$signed(rmq_pkg::LIM))))
    else $error("qw outside saturation range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("pipeline advanced while output stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
`default_nettype wire

/* rtl/core/rmq_sqrt.sv */
// Pipelined integer square root, one result bit per stage, floor root and remainder.
// Uses rmq_pkg for widths and the sideband struct.
`default_nettype none
module rmq_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [rmq_pkg::RAD_W-1:0]  in_rad,
  input  wire rmq_pkg::sqrt_side_t        in_side,
  output logic                            out_valid,
  output logic [rmq_pkg::ROOT_W-1:0]      out_root,
  output logic [rmq_pkg::REM_W-1:0]       out_rem,
  output rmq_pkg::sqrt_side_t             out_side
);

  localparam int N = rmq_pkg::ROOT_W;

  logic                        valid_r [1:N];
  logic [rmq_pkg::RAD_W-1:0]   rad_r   [1:N];
  logic [rmq_pkg::ROOT_W-1:0]  root_r  [1:N];
  logic [rmq_pkg::REM_W-1:0]   rem_r   [1:N];
  rmq_pkg::sqrt_side_t         side_r  [1:N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                       cur_valid;
    logic [rmq_pkg::RAD_W-1:0]  cur_rad;
    logic [rmq_pkg::ROOT_W-1:0] cur_root;
    logic [rmq_pkg::REM_W-1:0]  cur_rem;
    rmq_pkg::sqrt_side_t        cur_side;
    logic [rmq_pkg::REM_W-1:0]  sh;
    logic [rmq_pkg::REM_W-1:0]  trial;
    logic                       ge;

    if (k == 0) begin : g_src0
      assign cur_valid = in_valid;
      assign cur_rad   = in_rad;
      assign cur_root  = '0;
      assign cur_rem   = '0;
      assign cur_side  = in_side;
    end else begin : g_srck
      assign cur_valid = valid_r[k];
      assign cur_rad   = rad_r[k];
      assign cur_root  = root_r[k];
      assign cur_rem   = rem_r[k];
      assign cur_side  = side_r[k];
    end

    // bring down the next pair of radicand bits
    assign sh    = {cur_rem[rmq_pkg::REM_W-3:0], cur_rad[rmq_pkg::RAD_W-1-2*k -: 2]};
    assign trial = {1'b0, cur_root, 2'b01};
    assign ge    = (sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k+1] <= 1'b0;
      end else if (en) begin
        valid_r[k+1] <= cur_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k+1]  <= cur_rad;
        side_r[k+1] <= cur_side;
        rem_r[k+1]  <= ge ? (sh - trial) : sh;
        root_r[k+1] <= {cur_root[rmq_pkg::ROOT_W-2:0], ge};
      end
    end
  end

  assign out_valid = valid_r[N];
  assign out_root  = root_r[N];
  assign out_rem   = rem_r[N];
  assign out_side  = side_r[N];

endmodule
`default_nettype wire

/* rtl/core/rmq_div.sv */
// Three-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
// Uses rmq_pkg for widths and the sideband struct.
`default_nettype none
module rmq_div (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          en,
  input  wire logic                                          in_valid,
  input  wire logic [rmq_pkg::DEN_W-1:0]                     in_den,
  input  wire logic [rmq_pkg::LANES-1:0][rmq_pkg::NUM_W-1:0] in_num,
  input  wire rmq_pkg::div_side_t                            in_side,
  output logic                                               out_valid,
  output logic [rmq_pkg::LANES-1:0][rmq_pkg::QUO_W-1:0]      out_quo,
  output rmq_pkg::div_side_t                                 out_side
);

  localparam int N  = rmq_pkg::QUO_W;
  localparam int L  = rmq_pkg::LANES;
  localparam int PW = rmq_pkg::PREM_W;

  logic                            valid_r [1:N];
  logic [rmq_pkg::DEN_W-1:0]       den_r   [1:N];
  logic [L-1:0][N-1:0]             low_r   [1:N];
  logic [L-1:0][PW-1:0]            prem_r  [1:N];
  logic [L-1:0][N-1:0]             quo_r   [1:N];
  rmq_pkg::div_side_t              side_r  [1:N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                      cur_valid;
    logic [rmq_pkg::DEN_W-1:0] cur_den;
    logic [L-1:0][N-1:0]       cur_low;
    logic [L-1:0][PW-1:0]      cur_prem;
    logic [L-1:0][N-1:0]       cur_quo;
    rmq_pkg::div_side_t        cur_side;
    logic [L-1:0][PW-1:0]      nxt_prem;
    logic [L-1:0][N-1:0]       nxt_quo;

    if (k == 0) begin : g_src0
      // quotient fits N bits, so the high part of the dividend is below the divisor
      for (genvar j = 0; j < L; j++) begin : g_ld
        assign cur_low[j]  = in_num[j][N-1:0];
        assign cur_prem[j] = PW'(in_num[j][rmq_pkg::NUM_W-1:N]);
      end
      assign cur_valid = in_valid;
      assign cur_den   = in_den;
      assign cur_quo   = '0;
      assign cur_side  = in_side;
    end else begin : g_srck
      assign cur_valid = valid_r[k];
      assign cur_den   = den_r[k];
      assign cur_low   = low_r[k];
      assign cur_prem  = prem_r[k];
      assign cur_quo   = quo_r[k];
      assign cur_side  = side_r[k];
    end

    for (genvar j = 0; j < L; j++) begin : g_lane
      logic [PW:0] sh;
      logic        ge;
      assign sh = {cur_prem[j], cur_low[j][N-1-k]};
      assign ge = (sh >= {1'b0, cur_den});
      assign nxt_prem[j] = ge ? PW'(sh - {1'b0, cur_den}) : PW'(sh);
      assign nxt_quo[j]  = {cur_quo[j][N-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k+1] <= 1'b0;
      end else if (en) begin
        valid_r[k+1] <= cur_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k+1]  <= cur_den;
        low_r[k+1]  <= cur_low;
        side_r[k+1] <= cur_side;
        prem_r[k+1] <= nxt_prem;
        quo_r[k+1]  <= nxt_quo;
      end
    end
  end

  assign out_valid = valid_r[N];
  assign out_quo   = quo_r[N];
  assign out_side  = side_r[N];

endmodule
`default_nettype wire
